### design/uldcp_pkg.sv
// ----------------------------------------------------------------------------
// uldcp_pkg
// Shared types and constants of the LED dimmer command parser: the command
// and status bundles between controller and datapath, and default sizes.
// ----------------------------------------------------------------------------
package uldcp_pkg;

  localparam int LINE_CAPACITY_DEF = 30;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 32;

  typedef struct packed {
    logic store_wr;
    logic scan_start;
    logic scan_rd;
    logic exec;
    logic reply_load;
  } cmd_t;

  typedef struct packed {
    logic is_bang;
    logic is_eol;
    logic line_full;
    logic scan_done;
    logic has_match;
    logic out_free;
    logic reply_last;
  } sts_t;

endpackage

### design/uart_led_dimmer_command_parser.sv
// ----------------------------------------------------------------------------
// uart_led_dimmer_command_parser
// Text command parser for a dimmable LED: received bytes form a line, '!'
// runs the ON, OFF, PWM: or Status command in it and streams the reply.
//
//   Channel | Direction | Transaction
//   in_     | slave     | one received byte
//   out_    | master    | one reply character with the LED state after it
//
// A byte other than '!' is taken and the port is ready again at once. A '!'
// closes the input for the walk of the line buffer through its single read
// port, one stored byte a cycle, then for running the command, then for the
// reply characters while the output takes them; the reply is 15 to 32
// characters. A stalled output holds the reply sequencer; the last character
// may wait in the output register while the next byte is accepted.
// Reset (synchronous, active low) empties the line, turns the LED off and
// sets the duty to 50 per cent; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_led_dimmer_command_parser
  import uldcp_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] tx_char, [17:8] compare_value,
                                             // [18] led_enabled, [25:19] duty_now
  output logic                   out_tlast
);

  cmd_t cmd;
  sts_t sts;

  uldcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uldcp_dp #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

### design/uldcp_ram.sv
// ----------------------------------------------------------------------------
// uldcp_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module uldcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/uldcp_ctrl.sv
// ----------------------------------------------------------------------------
// uldcp_ctrl
// Controller of the command parser: collects bytes, walks the stored line,
// runs the matched command and sequences the reply characters.
// ----------------------------------------------------------------------------
module uldcp_ctrl
  import uldcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_REPLY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (sts.is_bang) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else if (!sts.is_eol && !sts.line_full) begin
            cmd.store_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.has_match ? S_REPLY : S_IDLE;
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.reply_load = 1'b1;
          if (sts.reply_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_exec_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE || state_r == S_REPLY)
    else $error("command execution did not return to idle or reply");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reply_load |-> sts.out_free)
    else $error("reply character loaded over an untaken one");

  a_reply_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLY && sts.out_free && sts.reply_last) |=> in_tready)
    else $error("input not reopened after the final reply character");

endmodule

### design/uldcp_dp.sv
// ----------------------------------------------------------------------------
// uldcp_dp
// Datapath of the command parser: line buffer, keyword matching and digit
// accumulation during the line walk, LED state, and the reply character
// generator with its output register.
// ----------------------------------------------------------------------------
module uldcp_dp
  import uldcp_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [7:0]             in_byte,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [8*2-1:0] KW_ON  = "ON";
  localparam logic [8*3-1:0] KW_OFF = "OFF";
  localparam logic [8*4-1:0] KW_PWM = "PWM:";
  localparam logic [8*6-1:0] KW_ST  = "Status";

  localparam logic [8*15-1:0] TX_ON   = ">> Da bat LED\r\n";
  localparam logic [8*15-1:0] TX_OFF  = ">> Da tat LED\r\n";
  localparam logic [8*19-1:0] TX_PWM  = ">> Da luu PWM moi\r\n";
  localparam logic [8*15-1:0] TX_HEAD = ">> Trang thai: ";
  localparam logic [8*4-1:0]  TX_SON  = "ON, ";
  localparam logic [8*5-1:0]  TX_SOFF = "OFF, ";
  localparam logic [8*6-1:0]  TX_SPWM = "PWM = ";
  localparam logic [8*3-1:0]  TX_TAIL = "%\r\n";

  localparam logic [1:0] K_ON     = 2'd0;
  localparam logic [1:0] K_OFF    = 2'd1;
  localparam logic [1:0] K_PWM    = 2'd2;
  localparam logic [1:0] K_STATUS = 2'd3;

  localparam logic [6:0] DUTY_RST = 7'd50;
  localparam logic [7:0] DUTY_MAX = 8'd100;

  function automatic logic [7:0] status_char(
    input logic [4:0] k,
    input logic       on,
    input logic [1:0] nd,
    input logic [3:0] hd,
    input logic [3:0] td,
    input logic [3:0] od
  );
    logic [4:0] j;
    logic [4:0] ol;
    logic [3:0] dg;
    logic [7:0] ch;
    ch = CH_NUL;
    dg = od;
    ol = on ? 5'd4 : 5'd5;
    j  = k;
    if (k < 5'd15) begin
      ch = TX_HEAD[8*(14-k) +: 8];
    end else begin
      j = k - 5'd15;
      if (j < ol) begin
        ch = on ? TX_SON[8*(3-j) +: 8] : TX_SOFF[8*(4-j) +: 8];
      end else begin
        j = j - ol;
        if (j < 5'd6) begin
          ch = TX_SPWM[8*(5-j) +: 8];
        end else begin
          j = j - 5'd6;
          if (j < {3'b000, nd}) begin
            if (nd == 2'd3) begin
              dg = (j == 5'd0) ? hd : ((j == 5'd1) ? td : od);
            end else if (nd == 2'd2) begin
              dg = (j == 5'd0) ? td : od;
            end
            ch = CH_ZERO + {4'h0, dg};
          end else begin
            j = j - {3'b000, nd};
            if (j < 5'd3) begin
              ch = TX_TAIL[8*(2-j) +: 8];
            end
          end
        end
      end
    end
    return ch;
  endfunction

  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             proc_v_r, proc_v_nxt;
  logic             m_on_r, m_on_nxt;
  logic             m_off_r, m_off_nxt;
  logic             m_pwm_r, m_pwm_nxt;
  logic             m_st_r, m_st_nxt;
  logic             stop_r, stop_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic             on_r, on_nxt;
  logic [6:0]       duty_r, duty_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [4:0]       rpos_r, rpos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [7:0]  rd_data;
  logic [7:0]  ch;
  logic        is_digit;
  logic        hit_on, hit_off, hit_pwm, hit_st;
  logic [14:0] div_prod;
  logic [3:0]  q10;
  logic [6:0]  ones7;
  logic [3:0]  hd, td, od;
  logic [1:0]  nd;
  logic [5:0]  reply_len;
  logic [9:0]  cmp;
  logic [7:0]  tx_char;
  logic [4:0]  k;

  uldcp_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAPACITY)
  ) u_line (
    .clk  (clk),
    .we   (cmd.store_wr),
    .waddr(fill_r[AW-1:0]),
    .wdata(in_byte),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_data)
  );

  assign ch       = rd_data;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  assign hit_on  = m_on_r  && (fill_r >= CW'(2));
  assign hit_off = m_off_r && (fill_r >= CW'(3));
  assign hit_pwm = m_pwm_r && (fill_r >= CW'(4));
  assign hit_st  = m_st_r  && (fill_r >= CW'(6));

  assign div_prod = {8'h00, duty_r} * 15'd205;
  assign q10      = div_prod[14:11];
  assign ones7    = duty_r - ({3'b000, q10} * 7'd10);
  assign od       = ones7[3:0];
  assign hd       = (q10 == 4'd10) ? 4'd1 : 4'd0;
  assign td       = (q10 == 4'd10) ? 4'd0 : q10;
  assign nd       = (duty_r >= 7'd100) ? 2'd3 : ((duty_r >= 7'd10) ? 2'd2 : 2'd1);
  assign cmp      = on_r ? ({duty_r, 3'b000} + {2'b00, duty_r, 1'b0}) : 10'd0;
  assign k        = rpos_r;

  always_comb begin
    case (kind_r)
      K_ON:     reply_len = 6'd15;
      K_OFF:    reply_len = 6'd15;
      K_PWM:    reply_len = 6'd19;
      K_STATUS: reply_len = 6'd24 + (on_r ? 6'd4 : 6'd5) + {4'h0, nd};
      default:  reply_len = 6'd15;
    endcase
  end

  always_comb begin
    case (kind_r)
      K_ON:     tx_char = TX_ON[8*(14-k) +: 8];
      K_OFF:    tx_char = TX_OFF[8*(14-k) +: 8];
      K_PWM:    tx_char = TX_PWM[8*(18-k) +: 8];
      K_STATUS: tx_char = status_char(k, on_r, nd, hd, td, od);
      default:  tx_char = CH_NUL;
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    proc_v_nxt    = 1'b0;
    m_on_nxt      = m_on_r;
    m_off_nxt     = m_off_r;
    m_pwm_nxt     = m_pwm_r;
    m_st_nxt      = m_st_r;
    stop_nxt      = stop_r;
    acc_nxt       = acc_r;
    on_nxt        = on_r;
    duty_nxt      = duty_r;
    kind_nxt      = kind_r;
    rpos_nxt      = rpos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (cmd.store_wr) begin
      fill_nxt = fill_r + CW'(1);
    end

    if (cmd.scan_start) begin
      idx_nxt   = '0;
      m_on_nxt  = 1'b1;
      m_off_nxt = 1'b1;
      m_pwm_nxt = 1'b1;
      m_st_nxt  = 1'b1;
      stop_nxt  = 1'b0;
      acc_nxt   = 8'h00;
    end

    if (cmd.scan_rd && (idx_r < fill_r)) begin
      idx_nxt    = idx_r + CW'(1);
      pos_nxt    = idx_r;
      proc_v_nxt = 1'b1;
    end

    if (proc_v_r) begin
      if (pos_r < CW'(2) && ch != KW_ON[8*(1-pos_r[2:0]) +: 8]) begin
        m_on_nxt = 1'b0;
      end
      if (pos_r < CW'(3) && ch != KW_OFF[8*(2-pos_r[2:0]) +: 8]) begin
        m_off_nxt = 1'b0;
      end
      if (pos_r < CW'(4) && ch != KW_PWM[8*(3-pos_r[2:0]) +: 8]) begin
        m_pwm_nxt = 1'b0;
      end
      if (pos_r < CW'(6) && ch != KW_ST[8*(5-pos_r[2:0]) +: 8]) begin
        m_st_nxt = 1'b0;
      end
      if (pos_r >= CW'(4) && !stop_r) begin
        if (ch == CH_PCT || ch == CH_NUL) begin
          stop_nxt = 1'b1;
        end else if (is_digit) begin
          acc_nxt = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0} + (ch - CH_ZERO);
        end
      end
    end

    if (cmd.exec) begin
      fill_nxt = '0;
      rpos_nxt = 5'd0;
      if (hit_on) begin
        on_nxt   = 1'b1;
        kind_nxt = K_ON;
      end else if (hit_off) begin
        on_nxt   = 1'b0;
        kind_nxt = K_OFF;
      end else if (hit_pwm) begin
        duty_nxt = (acc_r > DUTY_MAX) ? DUTY_MAX[6:0] : acc_r[6:0];
        kind_nxt = K_PWM;
      end else if (hit_st) begin
        kind_nxt = K_STATUS;
      end
    end

    if (cmd.reply_load) begin
      rpos_nxt      = rpos_r + 5'd1;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'b000000, duty_r, on_r, cmp, tx_char};
      out_last_nxt  = sts.reply_last;
    end
  end

  always_comb begin
    sts.is_bang    = (in_byte == CH_BANG);
    sts.is_eol     = (in_byte == CH_CR) || (in_byte == CH_LF);
    sts.line_full  = (fill_r == CW'(LINE_CAPACITY));
    sts.scan_done  = (idx_r == fill_r) && !proc_v_r;
    sts.has_match  = hit_on || hit_off || hit_pwm || hit_st;
    sts.out_free   = !out_valid_r || out_tready;
    sts.reply_last = ({1'b0, rpos_r} == (reply_len - 6'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      proc_v_r    <= 1'b0;
      on_r        <= 1'b0;
      duty_r      <= DUTY_RST;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      proc_v_r    <= proc_v_nxt;
      on_r        <= on_nxt;
      duty_r      <= duty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    m_on_r     <= m_on_nxt;
    m_off_r    <= m_off_nxt;
    m_pwm_r    <= m_pwm_nxt;
    m_st_r     <= m_st_nxt;
    stop_r     <= stop_nxt;
    acc_r      <= acc_nxt;
    kind_r     <= kind_nxt;
    rpos_r     <= rpos_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LINE_CAPACITY))
    else $error("line fill count beyond the buffer capacity");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    proc_v_r |-> pos_r < fill_r)
    else $error("line walk read beyond the stored bytes");

  a_exec_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> fill_r == '0)
    else $error("line not cleared after the terminator");

endmodule
